[rtl/htok_pkg.sv]
// Types, byte codes and the byte classifier shared by the request head tokenizer.
// No dependencies.
package htok_pkg;

    localparam logic [7:0] BYTE_SP    = 8'h20;
    localparam logic [7:0] BYTE_DOT   = 8'h2e;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_COLON = 8'h3a;
    localparam logic [7:0] BYTE_H     = 8'h48;
    localparam logic [7:0] BYTE_T     = 8'h54;
    localparam logic [7:0] BYTE_P     = 8'h50;
    localparam logic [7:0] BYTE_SLASH = 8'h2f;

    localparam logic [1:0] EV_REQ_LINE = 2'd0;
    localparam logic [1:0] EV_HEADER   = 2'd1;
    localparam logic [1:0] EV_MSG_END  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_buffer;
    } t_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] first_start;
        logic [15:0] first_end;
        logic [15:0] second_start;
        logic [15:0] second_end;
        logic [7:0]  major_char;
        logic [7:0]  minor_char;
    } t_result;

    typedef enum logic [2:0] {
        CLS_SP,
        CLS_DOT,
        CLS_CR,
        CLS_LF,
        CLS_COLON,
        CLS_VERSION_LETTER,
        CLS_OTHER
    } t_byte_class;

    // One classified byte, as handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        t_byte_class cls;
        logic [15:0] off;
        logic [15:0] nxt;
        logic        last;
    } t_token;

    typedef enum logic [3:0] {
        PH_METHOD      = 4'd0,
        PH_MAJOR       = 4'd1,
        PH_MINOR       = 4'd2,
        PH_PATH        = 4'd3,
        PH_KEY         = 4'd4,
        PH_VALUE       = 4'd5,
        PH_MINOR_CR    = 4'd6,
        PH_LINE_START  = 4'd7,
        PH_BLANK_CR    = 4'd8,
        PH_VALUE_FIRST = 4'd9,
        PH_VALUE_CR    = 4'd10
    } t_phase;

    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        case (b)
            BYTE_SP:    c = CLS_SP;
            BYTE_DOT:   c = CLS_DOT;
            BYTE_CR:    c = CLS_CR;
            BYTE_LF:    c = CLS_LF;
            BYTE_COLON: c = CLS_COLON;
            BYTE_H, BYTE_T, BYTE_P, BYTE_SLASH: c = CLS_VERSION_LETTER;
            default:    c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

[rtl/htok_front.sv]
// Front of the tokenizer: accepts bytes, classifies them and stamps buffer offsets.
// Depends on htok_pkg.
module htok_front import htok_pkg::*; #(
    parameter longint unsigned BUFFER_BYTES = 65536
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_item  i_item,
    output t_token o_token
);

    logic [15:0] r_offset;
    logic [15:0] n_offset;
    logic [16:0] w_inc;
    logic [15:0] w_nxt;

    assign w_inc = {1'b0, r_offset} + 17'd1;
    // Wrap at the buffer size; above 64 KiB the 16-bit counter wraps by itself.
    assign w_nxt = (64'(w_inc) >= BUFFER_BYTES) ? 16'd0 : w_inc[15:0];

    always_comb begin
        n_offset = r_offset;
        if (i_accept) begin
            n_offset = i_item.last_in_buffer ? 16'd0 : w_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 16'd0;
        end else begin
            r_offset <= n_offset;
        end
    end

    assign o_token.data_byte = i_item.data_byte;
    assign o_token.cls       = classify(i_item.data_byte);
    assign o_token.off       = r_offset;
    assign o_token.nxt       = w_nxt;
    assign o_token.last      = i_item.last_in_buffer;

endmodule

[rtl/htok_queue.sv]
// Short token queue between the front and the back of the tokenizer.
// Depends on htok_pkg.
module htok_queue import htok_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_data,
    output logic   o_full,
    output logic   o_empty,
    input  logic   i_pop,
    output t_token o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/htok_back.sv]
// Back of the tokenizer: parse state machine over classified bytes and the result register.
// Depends on htok_pkg.
module htok_back import htok_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_token,
    output logic    o_tok_take,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    t_phase      r_phase;
    t_phase      n_phase;
    t_phase      w_phase;
    logic [15:0] r_span_begin,  n_span_begin;
    logic [15:0] r_method_beg,  n_method_beg;
    logic [15:0] r_method_end,  n_method_end;
    logic [15:0] r_path_beg,    n_path_beg;
    logic [15:0] r_path_end,    n_path_end;
    logic [15:0] r_key_beg,     n_key_beg;
    logic [15:0] r_key_end,     n_key_end;
    logic [15:0] r_cr_offset,   n_cr_offset;
    logic [7:0]  r_held_major,  n_held_major;
    logic [7:0]  r_held_minor,  n_held_minor;
    logic        r_out_valid;
    t_result     r_out;
    logic        w_emit;
    t_result     w_event;
    logic        w_not_lf;

    assign w_not_lf   = (i_token.cls != CLS_LF);
    assign o_tok_take = i_tok_valid && (!r_out_valid || i_pop);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    // A pending CR that is not followed by LF falls back to its base phase.
    always_comb begin
        w_phase = r_phase;
        if (w_not_lf) begin
            case (r_phase)
                PH_MINOR_CR: w_phase = PH_MINOR;
                PH_BLANK_CR: w_phase = PH_KEY;
                PH_VALUE_CR: w_phase = PH_VALUE;
                default:     w_phase = r_phase;
            endcase
        end
    end

    // Next phase.
    always_comb begin
        n_phase = w_phase;
        case (w_phase)
            PH_PATH: begin
                if (i_token.cls == CLS_SP) n_phase = PH_MAJOR;
            end
            PH_MAJOR: begin
                if (i_token.cls == CLS_DOT) n_phase = PH_MINOR;
            end
            PH_MINOR: begin
                if (i_token.cls == CLS_CR) n_phase = PH_MINOR_CR;
            end
            PH_MINOR_CR: n_phase = PH_LINE_START;
            PH_LINE_START, PH_KEY: begin
                if (w_phase == PH_LINE_START && i_token.cls == CLS_CR) begin
                    n_phase = PH_BLANK_CR;
                end else if (i_token.cls == CLS_COLON) begin
                    n_phase = PH_VALUE_FIRST;
                end else begin
                    n_phase = PH_KEY;
                end
            end
            PH_BLANK_CR: n_phase = PH_METHOD;
            PH_VALUE_FIRST, PH_VALUE: begin
                if (i_token.cls == CLS_CR) begin
                    n_phase = PH_VALUE_CR;
                end else begin
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE_CR: n_phase = PH_LINE_START;
            default: begin
                n_phase = (i_token.cls == CLS_SP) ? PH_PATH : PH_METHOD;
            end
        endcase
    end

    // Span bookkeeping and events.
    always_comb begin
        n_span_begin = r_span_begin;
        n_method_beg = r_method_beg;
        n_method_end = r_method_end;
        n_path_beg   = r_path_beg;
        n_path_end   = r_path_end;
        n_key_beg    = r_key_beg;
        n_key_end    = r_key_end;
        n_cr_offset  = r_cr_offset;
        n_held_major = r_held_major;
        n_held_minor = r_held_minor;
        w_emit       = 1'b0;
        w_event      = '0;

        if (r_phase == PH_MINOR_CR && w_not_lf) begin
            n_held_minor = BYTE_CR;
        end

        case (w_phase)
            PH_PATH: begin
                if (i_token.cls == CLS_SP) begin
                    n_path_beg   = r_span_begin;
                    n_path_end   = i_token.off;
                    n_span_begin = i_token.nxt;
                end
            end
            PH_MAJOR: begin
                if (i_token.cls != CLS_DOT && i_token.cls != CLS_VERSION_LETTER) begin
                    n_held_major = i_token.data_byte;
                end
            end
            PH_MINOR: begin
                if (i_token.cls == CLS_CR) begin
                    n_cr_offset = i_token.off;
                end else begin
                    n_held_minor = i_token.data_byte;
                end
            end
            PH_MINOR_CR: begin
                w_emit               = 1'b1;
                w_event.event_kind   = EV_REQ_LINE;
                w_event.first_start  = r_method_beg;
                w_event.first_end    = r_method_end;
                w_event.second_start = r_path_beg;
                w_event.second_end   = r_path_end;
                w_event.major_char   = r_held_major;
                w_event.minor_char   = r_held_minor;
                n_span_begin         = i_token.nxt;
            end
            PH_LINE_START, PH_KEY: begin
                if (w_phase == PH_LINE_START && i_token.cls == CLS_CR) begin
                    n_cr_offset = i_token.off;
                end else if (i_token.cls == CLS_COLON) begin
                    n_key_beg    = r_span_begin;
                    n_key_end    = i_token.off;
                    n_span_begin = i_token.nxt;
                end
            end
            PH_BLANK_CR: begin
                w_emit             = 1'b1;
                w_event.event_kind = EV_MSG_END;
                n_span_begin       = i_token.nxt;
            end
            PH_VALUE_FIRST, PH_VALUE: begin
                if (i_token.cls == CLS_CR) begin
                    n_cr_offset = i_token.off;
                end else if (w_phase == PH_VALUE_FIRST && i_token.cls == CLS_SP) begin
                    // skip the single space after the colon
                    n_span_begin = i_token.nxt;
                end
            end
            PH_VALUE_CR: begin
                w_emit               = 1'b1;
                w_event.event_kind   = EV_HEADER;
                w_event.first_start  = r_key_beg;
                w_event.first_end    = r_key_end;
                w_event.second_start = r_span_begin;
                w_event.second_end   = r_cr_offset;
                n_span_begin         = i_token.nxt;
            end
            default: begin
                if (i_token.cls == CLS_SP) begin
                    n_method_beg = r_span_begin;
                    n_method_end = i_token.off;
                    n_span_begin = i_token.nxt;
                end
            end
        endcase

        if (i_token.last) begin
            n_span_begin = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_METHOD;
            r_span_begin <= 16'd0;
            r_method_beg <= 16'd0;
            r_method_end <= 16'd0;
            r_path_beg   <= 16'd0;
            r_path_end   <= 16'd0;
            r_key_beg    <= 16'd0;
            r_key_end    <= 16'd0;
            r_cr_offset  <= 16'd0;
            r_held_major <= 8'd0;
            r_held_minor <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_tok_take) begin
                r_phase      <= n_phase;
                r_span_begin <= n_span_begin;
                r_method_beg <= n_method_beg;
                r_method_end <= n_method_end;
                r_path_beg   <= n_path_beg;
                r_path_end   <= n_path_end;
                r_key_beg    <= n_key_beg;
                r_key_end    <= n_key_end;
                r_cr_offset  <= n_cr_offset;
                r_held_major <= n_held_major;
                r_held_minor <= n_held_minor;
                r_out_valid  <= w_emit;
            end else if (i_pop) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_take && w_emit) begin
            r_out <= w_event;
        end
    end

`ifndef SYNTHESIS
    a_emit_from_cr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_take && w_emit) |->
            (r_phase == PH_MINOR_CR || r_phase == PH_BLANK_CR || r_phase == PH_VALUE_CR))
        else $error("event emitted outside a pending-CR phase");

    a_msg_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_kind == EV_MSG_END) |->
            (r_out.first_start == 16'd0 && r_out.first_end == 16'd0 &&
             r_out.second_start == 16'd0 && r_out.second_end == 16'd0))
        else $error("message-end event carries nonzero spans");

    a_header_no_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_kind != EV_REQ_LINE) |->
            (r_out.major_char == 8'd0 && r_out.minor_char == 8'd0))
        else $error("version characters outside a request-line event");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.event_kind != 2'd3))
        else $error("illegal event kind");

    a_line_start_after_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_take && w_emit && r_phase != PH_BLANK_CR) |=> (r_phase == PH_LINE_START))
        else $error("phase did not return to line start after a line event");
`endif

endmodule

[rtl/http_request_head_tokenizer.sv]
// HTTP request head tokenizer, one byte per item, one event per completed line.
// Throughput: one byte per clock; the parse state machine in the back closes its loop each cycle.
// An event enters the result register at the edge on which the back takes its closing LF.
// A full result register with pop low stalls the back; the token queue then fills and raises full.
// Reset (synchronous, active low) clears the phase to method and all offsets and spans to zero.
// Depends on htok_pkg, htok_front, htok_queue and htok_back.
module http_request_head_tokenizer import htok_pkg::*; #(
    parameter longint unsigned BUFFER_BYTES = 65536,
    parameter int              QUEUE_DEPTH  = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_token w_front_tok;
    t_token w_back_tok;
    logic   w_accept;
    logic   w_q_empty;
    logic   w_take;

    assign w_accept = push && !full;

    htok_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_item  (i_item),
        .o_token (w_front_tok)
    );

    htok_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_accept),
        .i_data (w_front_tok),
        .o_full (full),
        .o_empty(w_q_empty),
        .i_pop  (w_take),
        .o_data (w_back_tok)
    );

    htok_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok_valid(!w_q_empty),
        .i_token    (w_back_tok),
        .o_tok_take (w_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

[test/tb_http_request_head_tokenizer.sv]
// Testbench for http_request_head_tokenizer: drives request bytes through the push/full side
// and checks every popped event against a byte-level parse tracker kept in this file.
// Depends on htok_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module tb_http_request_head_tokenizer;
    import htok_pkg::*;

    localparam longint unsigned BUF_BYTES    = 65536;
    localparam int              LIMIT_CYCLES = 2_000_000;
    localparam int              TAIL_CYCLES  = 16;
    localparam int              RANDOM_ITEMS = 1300;
    localparam int              MAX_PRINTS   = 40;

    logic    i_clk;
    logic    i_rst_n  = 1'b0;
    logic    push     = 1'b0;
    logic    full;
    t_item   i_item   = '0;
    logic    empty;
    logic    pop      = 1'b0;
    t_result o_result;

    http_request_head_tokenizer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Parse tracker state
    t_phase      parse_ph   = PH_METHOD;
    logic [15:0] cur_off    = '0;
    logic [15:0] span_start = '0;
    logic [15:0] meth_start = '0;
    logic [15:0] meth_end   = '0;
    logic [15:0] path_start = '0;
    logic [15:0] path_end   = '0;
    logic [15:0] key_start  = '0;
    logic [15:0] key_end    = '0;
    logic [15:0] cr_at      = '0;
    logic [7:0]  ver_major  = '0;
    logic [7:0]  ver_minor  = '0;
    t_result     pending_events[$];

    int error_count  = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int gap_max      = 6;
    bit corrupt_on   = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;
    int stall_pct    = 0;
    int pattern_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
                     pending_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTS)
            $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
                     cycle_count);
        error_count++;
    endtask

    // Advance the tracker by one accepted byte and queue the event it closes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [15:0] off;
        logic [15:0] nxt;
        t_result     ev;
        bit          fire;
        off  = cur_off;
        nxt  = (longint'(off) + 1 >= BUF_BYTES) ? 16'd0 : off + 16'd1;
        ev   = '0;
        fire = 1'b0;

        // A held CR that is not part of a CRLF drops back to its base phase.
        if (b != BYTE_LF) begin
            case (parse_ph)
                PH_MINOR_CR: begin
                    ver_minor = BYTE_CR;
                    parse_ph  = PH_MINOR;
                end
                PH_BLANK_CR: parse_ph = PH_KEY;
                PH_VALUE_CR: parse_ph = PH_VALUE;
                default: ;
            endcase
        end

        case (parse_ph)
            PH_PATH: begin
                if (b == BYTE_SP) begin
                    path_start = span_start;
                    path_end   = off;
                    span_start = nxt;
                    parse_ph   = PH_MAJOR;
                end
            end
            PH_MAJOR: begin
                if (b == BYTE_DOT)
                    parse_ph = PH_MINOR;
                else if (!(b inside {BYTE_H, BYTE_T, BYTE_P, BYTE_SLASH}))
                    ver_major = b;
            end
            PH_MINOR: begin
                if (b == BYTE_CR) begin
                    cr_at    = off;
                    parse_ph = PH_MINOR_CR;
                end else begin
                    ver_minor = b;
                end
            end
            PH_MINOR_CR: begin
                ev.event_kind   = EV_REQ_LINE;
                ev.first_start  = meth_start;
                ev.first_end    = meth_end;
                ev.second_start = path_start;
                ev.second_end   = path_end;
                ev.major_char   = ver_major;
                ev.minor_char   = ver_minor;
                fire            = 1'b1;
                span_start      = nxt;
                parse_ph        = PH_LINE_START;
            end
            PH_LINE_START, PH_KEY: begin
                if (parse_ph == PH_LINE_START && b == BYTE_CR) begin
                    cr_at    = off;
                    parse_ph = PH_BLANK_CR;
                end else if (b == BYTE_COLON) begin
                    key_start  = span_start;
                    key_end    = off;
                    span_start = nxt;
                    parse_ph   = PH_VALUE_FIRST;
                end else begin
                    parse_ph = PH_KEY;
                end
            end
            PH_BLANK_CR: begin
                ev.event_kind = EV_MSG_END;
                fire          = 1'b1;
                span_start    = nxt;
                parse_ph      = PH_METHOD;
            end
            PH_VALUE_FIRST, PH_VALUE: begin
                if (b == BYTE_CR) begin
                    cr_at    = off;
                    parse_ph = PH_VALUE_CR;
                end else if (parse_ph == PH_VALUE_FIRST && b == BYTE_SP) begin
                    span_start = nxt;
                    parse_ph   = PH_VALUE;
                end else begin
                    parse_ph = PH_VALUE;
                end
            end
            PH_VALUE_CR: begin
                ev.event_kind   = EV_HEADER;
                ev.first_start  = key_start;
                ev.first_end    = key_end;
                ev.second_start = span_start;
                ev.second_end   = cr_at;
                fire            = 1'b1;
                span_start      = nxt;
                parse_ph        = PH_LINE_START;
            end
            default: begin
                parse_ph = PH_METHOD;
                if (b == BYTE_SP) begin
                    meth_start = span_start;
                    meth_end   = off;
                    span_start = nxt;
                    parse_ph   = PH_PATH;
                end
            end
        endcase

        if (last) begin
            cur_off    = '0;
            span_start = '0;
        end else begin
            cur_off = nxt;
        end
        if (fire)
            pending_events.push_back(ev);
    endtask

    // Offer one byte, possibly idling first when the current burst is used up; returns after the transfer.
    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push   <= 1'b1;
        i_item <= '{data_byte: b, last_in_buffer: last};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_byte(b, last);
        items_sent++;
        burst_left--;
    endtask

    task automatic put_str(input string s);
        foreach (s[i]) put_byte(s[i], 1'b0);
    endtask

    task automatic put_crlf();
        put_byte(BYTE_CR, 1'b0);
        put_byte(BYTE_LF, 1'b0);
    endtask

    // Stop offering, let every expected event drain, then give the pipeline time to settle.
    task automatic wait_drained();
        push <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] special_byte();
        logic [7:0] v;
        case ($urandom_range(0, 6))
            0: v = BYTE_SP;
            1: v = BYTE_DOT;
            2: v = BYTE_CR;
            3: v = BYTE_LF;
            4: v = BYTE_COLON;
            5: v = BYTE_H;
            default: v = BYTE_SLASH;
        endcase
        return v;
    endfunction

    // Mostly printable text, sometimes any byte, never one of the two delimiters given.
    function automatic logic [7:0] pick_byte(input logic [7:0] skip_a, input logic [7:0] skip_b);
        logic [7:0] v;
        do begin
            v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(33, 126));
        end while (v == skip_a || v == skip_b);
        return v;
    endfunction

    task automatic put_rand(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (corrupt_on && $urandom_range(0, 24) == 0)
            v = special_byte();
        put_byte(v, $urandom_range(0, 49) == 0);
    endtask

    // Request line, up to four header lines and the blank line, with random content.
    task automatic send_random_request(input bit corrupt);
        int    n;
        int    h;
        int    k;
        string ver;
        ver        = "HTTP/";
        corrupt_on = corrupt;
        n = $urandom_range(1, 6);
        repeat (n) put_rand(pick_byte(BYTE_SP, BYTE_SP));
        put_rand(BYTE_SP);
        n = $urandom_range(1, 10);
        repeat (n) put_rand(pick_byte(BYTE_SP, BYTE_SP));
        put_rand(BYTE_SP);
        if ($urandom_range(0, 3) != 0)
            foreach (ver[i]) put_rand(ver[i]);
        put_rand(pick_byte(BYTE_DOT, BYTE_CR));
        put_rand(BYTE_DOT);
        put_rand(pick_byte(BYTE_CR, BYTE_CR));
        put_rand(BYTE_CR);
        put_rand(BYTE_LF);
        h = $urandom_range(0, 4);
        repeat (h) begin
            k = $urandom_range(1, 8);
            repeat (k) put_rand(pick_byte(BYTE_COLON, BYTE_CR));
            put_rand(BYTE_COLON);
            k = $urandom_range(0, 2);
            repeat (k) put_rand(BYTE_SP);
            k = $urandom_range(0, 10);
            repeat (k) put_rand(pick_byte(BYTE_CR, BYTE_CR));
            put_rand(BYTE_CR);
            put_rand(BYTE_LF);
        end
        put_rand(BYTE_CR);
        put_rand(BYTE_LF);
        corrupt_on = 1'b0;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 20);
        repeat (n) put_rand($urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255)));
    endtask

    task automatic test_basic_request();
        put_str("G / HTTP/1.1");
        put_crlf();
        put_str("K: v");
        put_crlf();
        put_crlf();
        wait_drained();
    endtask

    // Stray major letters, a lone CR in the minor, and a major that keeps its old value.
    task automatic test_version_chars();
        put_str("M / Hx9.");
        put_byte(BYTE_CR, 1'b0);
        put_crlf();
        put_crlf();
        put_str("N / HTTP/.");
        put_byte(BYTE_CR, 1'b0);
        put_str("7");
        put_crlf();
        wait_drained();
    endtask

    // Lone CR in a key and in a value, no space after the colon, two spaces, empty value.
    task automatic test_header_cases();
        put_byte(BYTE_CR, 1'b0);
        put_str("K:v");
        put_crlf();
        put_str("A:  w");
        put_byte(BYTE_CR, 1'b0);
        put_str("x");
        put_crlf();
        put_str("B:");
        put_crlf();
        put_crlf();
        wait_drained();
    endtask

    // Buffer ends inside the path and on the colon; extreme byte values inside spans.
    task automatic test_buffer_boundary();
        put_str("GET /");
        put_byte(8'h00, 1'b0);
        put_byte("b", 1'b1);
        put_str(" HTTP/1.1");
        put_crlf();
        put_byte(8'hff, 1'b0);
        put_byte(BYTE_COLON, 1'b1);
        put_str(" v");
        put_crlf();
        put_crlf();
        wait_drained();
    endtask

    // Hold the result side off long enough that the input side has to stall.
    task automatic test_backpressure();
        hold_request = 300;
        put_str("P /q HTTP/1.0");
        put_crlf();
        put_str("A: 1");
        put_crlf();
        put_str("B: 2");
        put_crlf();
        put_str("C: 3");
        put_crlf();
        put_crlf();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int target;
        int r;
        bit paused;
        target = items_sent + RANDOM_ITEMS;
        paused = 1'b0;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                send_random_request(r < 12);
            else
                send_noise();
            if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // Result side: stall on a changing duty pattern, or hold off for a requested stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(8, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            pattern_left--;
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each popped event with the oldest one expected.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected event kind", o_result.event_kind, 0);
            end else begin
                want = pending_events.pop_front();
                if (o_result.event_kind != want.event_kind)
                    report_mismatch("event_kind", o_result.event_kind, want.event_kind);
                if (o_result.first_start != want.first_start)
                    report_mismatch("first_start", o_result.first_start, want.first_start);
                if (o_result.first_end != want.first_end)
                    report_mismatch("first_end", o_result.first_end, want.first_end);
                if (o_result.second_start != want.second_start)
                    report_mismatch("second_start", o_result.second_start, want.second_start);
                if (o_result.second_end != want.second_end)
                    report_mismatch("second_end", o_result.second_end, want.second_end);
                if (o_result.major_char != want.major_char)
                    report_mismatch("major_char", o_result.major_char, want.major_char);
                if (o_result.minor_char != want.minor_char)
                    report_mismatch("minor_char", o_result.minor_char, want.minor_char);
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_request();
        test_version_chars();
        test_header_cases();
        test_buffer_boundary();
        test_backpressure();
        test_random_traffic();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[http_request_head_tokenizer.f]
rtl/htok_pkg.sv
rtl/htok_front.sv
rtl/htok_queue.sv
rtl/htok_back.sv
rtl/http_request_head_tokenizer.sv
test/tb_http_request_head_tokenizer.sv
